>>> hdl/assert_macros.svh
// Assertion macros used by the block's top-level RTL file.
// Depends on nothing; the using module must have aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define NCE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("nce assertion failed");

// Check that a condition holds in the cycle after a trigger
`define NCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nce assertion failed");

`endif

>>> hdl/nce_pkg.sv
// Types and constants of the nonzero coordinate emitter.
// No dependencies; imported by nonzero_coordinate_emitter_top and the testbench.
package nce_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int CNT_BITS       = 24;
    localparam int DIM_BITS       = 3;
    localparam int OUT_COORD_BITS = 16;
    localparam int ADDR_BITS      = 27;
    localparam int SIZE_BITS      = 16;
    localparam int NUM_SIZE_REGS  = 5;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CNT_BITS-1:0]   CNT_MAX        = {CNT_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] FLOAT_MAG_MASK = 32'h7FFF_FFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DATA_IS_FLOAT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIM_COUNT     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_DIM0     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_DIM4     = 3'd6;

    // Request types
    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_EMIT  = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [VALUE_BITS-1:0] elem_value;
        logic                  elem_last;
    } in_word_t;

    typedef struct packed {
        logic                      is_count;
        logic [CNT_BITS-1:0]       nonzero_total;
        logic [DIM_BITS-1:0]       dim_index;
        logic [OUT_COORD_BITS-1:0] coordinate;
        logic [ADDR_BITS-1:0]      write_address;
        logic                      run_last;
    } out_word_t;

endpackage

>>> hdl/nonzero_coordinate_emitter_top.sv
// Nonzero coordinate emitter: counts nonzero elements, then emits their coordinates.
// Depends on nce_pkg and assert_macros.svh.
//
//   channel | ports                          | carries
//   s_      | s_valid s_ready s_data         | one tensor element per word
//   m_      | m_valid m_ready m_data         | count report or one coordinate
//   cfg_    | cfg_wr_en cfg_index cfg_wdata  | register writes, no read-back
//
// An element is taken every cycle unless a run of coordinates is draining.
// A nonzero emit-pass element yields one word per dimension in use (dim_count
// held to 1..MAX_DIMS), one per cycle from the run register while the m_ side
// is not stalled, and the input waits until the last of them leaves the run register.
// The first result word passes through the run register, then the result register.
// Reset (aresetn low, synchronous) clears counts, odometer and registers to defaults.
// A stalled m_ side holds its word and the run register; input stalls after that.

module nonzero_coordinate_emitter_top #(
    parameter int MAX_DIMS   = 5,
    parameter int COORD_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [nce_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [nce_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  nce_pkg::in_word_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output nce_pkg::out_word_t                   m_data
);
    import nce_pkg::*;
`include "assert_macros.svh"

    localparam int CW      = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int SIZE_IW = $clog2(NUM_SIZE_REGS);

    // Configuration registers
    logic                 data_is_float_reg;
    logic [DIM_BITS-1:0]  dim_count_reg;
    logic [SIZE_BITS-1:0] size_dim_reg [NUM_SIZE_REGS];

    // Walk state
    logic [CNT_BITS-1:0]   nonzero_count_reg, nonzero_count_next;
    logic [CNT_BITS-1:0]   emit_index_reg, emit_index_next;
    logic                  restart_reg, restart_next;
    logic [COORD_BITS-1:0] odometer_reg [MAX_DIMS];
    logic [COORD_BITS-1:0] odometer_next [MAX_DIMS];
    logic [COORD_BITS-1:0] odometer_adv [MAX_DIMS];

    // Run register: results still to deliver for the last accepted word
    logic                  run_valid_reg, run_valid_next;
    logic                  run_is_count_reg, run_is_count_next;
    logic [CNT_BITS-1:0]   run_total_reg, run_total_next;
    logic [DIM_BITS-1:0]   run_dim_reg, run_dim_next;
    logic [DIM_BITS-1:0]   run_n_reg, run_n_next;
    logic [ADDR_BITS-1:0]  run_addr_reg, run_addr_next;
    logic [COORD_BITS-1:0] run_coord_reg [MAX_DIMS];
    logic [COORD_BITS-1:0] run_coord_next [MAX_DIMS];

    // Result register
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    logic                s_accept;
    logic                out_load;
    logic                run_at_last;
    logic                nonzero;
    logic [DIM_BITS-1:0] active_n;
    logic [CNT_BITS-1:0] count_base;
    logic                has_result;
    logic                count_end_accept;
    logic                emit_end_accept;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_is_float_reg <= 1'b0;
            dim_count_reg     <= DIM_BITS'(1);
            for (int i = 0; i < NUM_SIZE_REGS; i++) begin
                size_dim_reg[i] <= SIZE_BITS'(1);
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DATA_IS_FLOAT: data_is_float_reg <= cfg_wdata[0];
                REG_DIM_COUNT:     dim_count_reg     <= cfg_wdata[DIM_BITS-1:0];
                default: begin
                    if (cfg_index inside {[REG_SIZE_DIM0:REG_SIZE_DIM4]}) begin
                        size_dim_reg[SIZE_IW'(cfg_index - REG_SIZE_DIM0)] <= cfg_wdata;
                    end
                end
            endcase
        end
    end

    // Clamp dimension count to 1..MAX_DIMS
    always_comb begin
        if (dim_count_reg == '0) begin
            active_n = DIM_BITS'(1);
        end else if (dim_count_reg > DIM_BITS'(MAX_DIMS)) begin
            active_n = DIM_BITS'(MAX_DIMS);
        end else begin
            active_n = dim_count_reg;
        end
    end

    // Zero test: float mode ignores the sign bit
    assign nonzero = data_is_float_reg ? ((s_data.elem_value & FLOAT_MAG_MASK) != '0)
                                       : (s_data.elem_value != '0);

    // Advance the odometer, innermost active dimension first
    always_comb begin
        logic                  carry;
        logic [COORD_BITS-1:0] inc;
        logic                  wrap;
        carry = 1'b1;
        for (int d = MAX_DIMS - 1; d >= 0; d--) begin
            inc  = odometer_reg[d] + COORD_BITS'(1);
            wrap = (CW'(inc) >= CW'(size_dim_reg[d])) || (inc == '0);
            odometer_adv[d] = odometer_reg[d];
            if (DIM_BITS'(d) < active_n && carry) begin
                if (wrap) begin
                    odometer_adv[d] = '0;
                end else begin
                    odometer_adv[d] = inc;
                    carry           = 1'b0;
                end
            end
        end
    end

    // Handshake: take a word when the run register is empty or frees up this cycle
    assign run_at_last = (run_dim_reg + DIM_BITS'(1)) == run_n_reg;
    assign out_load    = run_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready     = !run_valid_reg || (out_load && run_at_last);
    assign s_accept    = s_valid && s_ready;

    assign count_base = restart_reg ? '0 : nonzero_count_reg;
    assign has_result = (s_data.req_type == REQ_COUNT) ? s_data.elem_last : nonzero;

    // Update walk state on an accepted word
    always_comb begin
        nonzero_count_next = nonzero_count_reg;
        emit_index_next    = emit_index_reg;
        restart_next       = restart_reg;
        odometer_next      = odometer_reg;
        if (s_accept) begin
            if (s_data.req_type == REQ_COUNT) begin
                nonzero_count_next = (nonzero && count_base < CNT_MAX)
                                   ? count_base + CNT_BITS'(1) : count_base;
                restart_next       = s_data.elem_last;
                emit_index_next    = '0;
                for (int d = 0; d < MAX_DIMS; d++) odometer_next[d] = '0;
            end else begin
                if (nonzero && emit_index_reg < CNT_MAX) begin
                    emit_index_next = emit_index_reg + CNT_BITS'(1);
                end
                if (s_data.elem_last) begin
                    emit_index_next = '0;
                    for (int d = 0; d < MAX_DIMS; d++) odometer_next[d] = '0;
                end else begin
                    odometer_next = odometer_adv;
                end
            end
        end
    end

    // Load, step or drop the run register
    always_comb begin
        run_valid_next    = run_valid_reg;
        run_is_count_next = run_is_count_reg;
        run_total_next    = run_total_reg;
        run_dim_next      = run_dim_reg;
        run_n_next        = run_n_reg;
        run_addr_next     = run_addr_reg;
        run_coord_next    = run_coord_reg;
        if (out_load) begin
            if (run_at_last) begin
                run_valid_next = 1'b0;
            end else begin
                run_dim_next  = run_dim_reg + DIM_BITS'(1);
                run_addr_next = run_addr_reg + ADDR_BITS'(run_total_reg);
                for (int d = 0; d < MAX_DIMS - 1; d++) run_coord_next[d] = run_coord_reg[d+1];
                run_coord_next[MAX_DIMS-1] = '0;
            end
        end
        if (s_accept && has_result) begin
            run_valid_next = 1'b1;
            run_dim_next   = '0;
            if (s_data.req_type == REQ_COUNT) begin
                run_is_count_next = 1'b1;
                run_total_next    = nonzero_count_next;
                run_n_next        = DIM_BITS'(1);
                run_addr_next     = '0;
                for (int d = 0; d < MAX_DIMS; d++) run_coord_next[d] = '0;
            end else begin
                run_is_count_next = 1'b0;
                run_total_next    = nonzero_count_reg;
                run_n_next        = active_n;
                run_addr_next     = ADDR_BITS'(emit_index_reg);
                run_coord_next    = odometer_reg;
            end
        end
    end

    // Fill the result register from the head of the run
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next               = 1'b1;
            m_data_next.is_count       = run_is_count_reg;
            m_data_next.nonzero_total  = run_total_reg;
            m_data_next.dim_index      = run_dim_reg;
            m_data_next.coordinate     = OUT_COORD_BITS'(run_coord_reg[0]);
            m_data_next.write_address  = run_addr_reg;
            m_data_next.run_last       = run_at_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonzero_count_reg <= '0;
            emit_index_reg    <= '0;
            restart_reg       <= 1'b0;
            for (int d = 0; d < MAX_DIMS; d++) odometer_reg[d] <= '0;
            run_valid_reg     <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            nonzero_count_reg <= nonzero_count_next;
            emit_index_reg    <= emit_index_next;
            restart_reg       <= restart_next;
            odometer_reg      <= odometer_next;
            run_valid_reg     <= run_valid_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        run_is_count_reg <= run_is_count_next;
        run_total_reg    <= run_total_next;
        run_dim_reg      <= run_dim_next;
        run_n_reg        <= run_n_next;
        run_addr_reg     <= run_addr_next;
        run_coord_reg    <= run_coord_next;
        m_data_reg       <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    assign count_end_accept = s_accept && s_data.req_type == REQ_COUNT && s_data.elem_last;
    assign emit_end_accept  = s_accept && s_data.req_type == REQ_EMIT && s_data.elem_last;

    `NCE_ASSERT(a_run_dim_in_range, !run_valid_reg || (run_dim_reg < run_n_reg))
    `NCE_ASSERT(a_count_word_single, !(m_valid_reg && m_data_reg.is_count) || m_data_reg.run_last)
    `NCE_ASSERT_NEXT(a_restart_after_count_end, count_end_accept, restart_reg)
    `NCE_ASSERT_NEXT(a_emit_end_clears_walk, emit_end_accept, emit_index_reg == '0)

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for nonzero_coordinate_emitter_top: count and emit passes
// over directed and random shapes, compared word by word against an in-bench predictor.
// Depends on nce_pkg and the RTL of the block only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nce_pkg::*;

    localparam int MAX_DIMS   = 5;
    localparam int DRAIN_GAP  = 10;
    localparam int HOLD_LONG  = 150;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    in_word_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_word_t          m_data;

    // Knobs shared by the sender, the receiver and the tests
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          hold_left     = 0;

    // Run statistics and failures
    int unsigned elements_sent  = 0;
    int unsigned shapes_loaded  = 0;
    int unsigned count_reports  = 0;
    int unsigned coord_words    = 0;
    int unsigned faults         = 0;

    // Predictor state: configuration copy, counters and odometer
    logic              cur_float = 1'b0;
    logic [2:0]        cur_dims  = 3'd1;
    logic [15:0]       cur_extent [5] = '{default: 16'd1};
    logic [CNT_BITS-1:0] nz_count  = '0;
    logic [CNT_BITS-1:0] emit_pos  = '0;
    logic [15:0]       odo [5]  = '{default: 16'd0};
    logic              count_restart = 1'b0;
    out_word_t         owed_words [$];

    nonzero_coordinate_emitter_top #(
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (16)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int dims_in_use();
        if (cur_dims == 3'd0) return 1;
        if (cur_dims > 3'(MAX_DIMS)) return MAX_DIMS;
        return int'(cur_dims);
    endfunction

    function automatic void reset_walk();
        foreach (odo[d]) odo[d] = '0;
        emit_pos = '0;
    endfunction

    // Advance the innermost coordinate, carry outward; zero extent acts as one
    function automatic void step_odometer(input int n);
        logic [15:0] nxt;
        for (int k = n; k > 0; k--) begin
            nxt = odo[k-1] + 16'd1;
            if (nxt >= cur_extent[k-1] || nxt == 16'd0) begin
                odo[k-1] = '0;
            end else begin
                odo[k-1] = nxt;
                return;
            end
        end
    endfunction

    // Work out the words that one accepted element owes and queue them
    function automatic void unravel_element(input in_word_t w);
        logic        nonzero;
        int          n;
        out_word_t   r;
        logic [31:0] addr;
        nonzero = cur_float ? ((w.elem_value & FLOAT_MAG_MASK) != '0) : (w.elem_value != '0);
        n = dims_in_use();
        if (w.req_type == REQ_COUNT) begin
            if (count_restart) begin
                nz_count      = '0;
                count_restart = 1'b0;
            end
            reset_walk();
            if (nonzero && nz_count != CNT_MAX) nz_count++;
            if (w.elem_last) begin
                r               = '0;
                r.is_count      = 1'b1;
                r.nonzero_total = nz_count;
                r.run_last      = 1'b1;
                owed_words.push_back(r);
                count_restart   = 1'b1;
            end
        end else begin
            if (nonzero) begin
                for (int d = 0; d < n; d++) begin
                    addr            = 32'(emit_pos) + 32'(d) * 32'(nz_count);
                    r.is_count      = 1'b0;
                    r.nonzero_total = nz_count;
                    r.dim_index     = 3'(d);
                    r.coordinate    = odo[d];
                    r.write_address = addr[ADDR_BITS-1:0];
                    r.run_last      = (d + 1 == n);
                    owed_words.push_back(r);
                end
                if (emit_pos != CNT_MAX) emit_pos++;
            end
            if (w.elem_last) reset_walk();
            else step_odometer(n);
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // Offer one word, idle at random first, hold it until taken
    task automatic send_word(input in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        unravel_element(w);
        elements_sent++;
    endtask

    // Send one pass over a tensor, marking the final element
    task automatic send_pass(input logic req, input logic [31:0] vals [$]);
        in_word_t w;
        foreach (vals[i]) begin
            w.req_type   = req;
            w.elem_value = vals[i];
            w.elem_last  = (i == vals.size() - 1);
            send_word(w);
        end
    endtask

    // Drop valid and wait until every owed word is back and the block settles
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (owed_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    // Write all seven registers back to back; call only while idle
    task automatic load_config(input logic fl, input logic [2:0] dims,
                               input logic [15:0] ext [5]);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DATA_IS_FLOAT;
        cfg_wdata <= CFG_DATA_BITS'(fl);
        @(posedge aclk);
        cfg_index <= REG_DIM_COUNT;
        cfg_wdata <= CFG_DATA_BITS'(dims);
        @(posedge aclk);
        for (int d = 0; d < NUM_SIZE_REGS; d++) begin
            cfg_index <= REG_SIZE_DIM0 + CFG_IDX_BITS'(d);
            cfg_wdata <= ext[d];
            @(posedge aclk);
        end
        cfg_wr_en  <= 1'b0;
        cur_float  = fl;
        cur_dims   = dims;
        cur_extent = ext;
        shapes_loaded++;
    endtask

    function automatic logic [31:0] random_element();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'h0;
            4:          return 32'h8000_0000;
            5:          return 32'h1 << $urandom_range(0, 31);
            default:    return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------- receiver and checker

    // Stall at random, or hold off for a counted stretch when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare every taken word against the oldest owed one
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_words.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display({"unexpected word: cnt=%0b tot=%0d dim=%0d crd=%0d ",
                              "addr=%0d last=%0b"},
                             m_data.is_count, m_data.nonzero_total, m_data.dim_index,
                             m_data.coordinate, m_data.write_address, m_data.run_last);
            end else begin
                want = owed_words.pop_front();
                if (want.is_count) count_reports++;
                else coord_words++;
                if (m_data.is_count      !== want.is_count      ||
                    m_data.nonzero_total !== want.nonzero_total ||
                    m_data.dim_index     !== want.dim_index     ||
                    m_data.coordinate    !== want.coordinate    ||
                    m_data.write_address !== want.write_address ||
                    m_data.run_last      !== want.run_last) begin
                    faults++;
                    if (faults <= 10)
                        $display({"mismatch: want cnt=%0b tot=%0d dim=%0d crd=%0d addr=%0d ",
                                  "last=%0b, got cnt=%0b tot=%0d dim=%0d crd=%0d ",
                                  "addr=%0d last=%0b"},
                                 want.is_count, want.nonzero_total, want.dim_index,
                                 want.coordinate, want.write_address, want.run_last,
                                 m_data.is_count, m_data.nonzero_total, m_data.dim_index,
                                 m_data.coordinate, m_data.write_address, m_data.run_last);
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Reset shape (one dimension of extent one): extra elements wrap the coordinate
    task automatic test_default_shape();
        logic [31:0] vals [$];
        vals = {32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
        send_pass(REQ_COUNT, vals);
        send_pass(REQ_EMIT, vals);
    endtask

    // Float mode: minus zero is zero, any magnitude bit is nonzero
    task automatic test_float_sign();
        logic [31:0] vals [$];
        wait_drained();
        load_config(1'b1, 3'd2, '{16'd2, 16'd2, 16'd1, 16'd1, 16'd1});
        vals = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0001};
        send_pass(REQ_COUNT, vals);
        send_pass(REQ_EMIT, vals);
    endtask

    // Dim count above the limit, zero and full extents, more nonzeros than counted
    task automatic test_extreme_shape();
        logic [31:0] vals [$];
        wait_drained();
        load_config(1'b0, 3'd7, '{16'd0, 16'hFFFF, 16'd2, 16'd1, 16'd3});
        vals = {32'h0000_0001, 32'h0000_0000, 32'h8000_0000};
        send_pass(REQ_COUNT, vals);
        vals = {32'h0000_0002, 32'h0000_0003, 32'h0000_0000, 32'hFFFF_FFFF};
        send_pass(REQ_EMIT, vals);
    endtask

    // Hold the receiver off long enough for the block to stall its input
    task automatic test_output_backpressure();
        logic [31:0] vals [$];
        wait_drained();
        load_config(1'b0, 3'd5, '{16'd3, 16'd1, 16'd1, 16'd2, 16'd2});
        vals.delete();
        repeat (12) vals.push_back($urandom | 32'h1);
        vals[5] = 32'h0;
        send_pass(REQ_COUNT, vals);
        hold_left = HOLD_LONG;
        send_pass(REQ_EMIT, vals);
        wait_drained();
    endtask

    // Well-formed count/emit sequences on random small shapes, with some noise
    task automatic test_random_tensors(input int unsigned quota);
        int unsigned start;
        int          n;
        int unsigned len;
        logic        fl;
        logic [2:0]  dims;
        logic [15:0] ext [5];
        logic [31:0] vals [$];
        in_word_t    w;
        start = elements_sent;
        while (elements_sent - start < quota) begin
            wait_drained();
            fl   = 1'($urandom_range(0, 1));
            dims = 3'($urandom_range(0, 7));
            foreach (ext[i]) ext[i] = 16'($urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0) ext[0] = 16'hFFFF;
            load_config(fl, dims, ext);
            n   = dims_in_use();
            len = 1;
            for (int d = 0; d < n; d++) len = len * ((ext[d] == 16'd0) ? 1 : ext[d]);
            if (len > 12) len = 12;
            // run a few elements past the shape now and then
            if ($urandom_range(0, 4) == 0) len += $urandom_range(1, 3);
            vals.delete();
            repeat (len) vals.push_back(random_element());
            send_pass(REQ_COUNT, vals);
            send_pass(REQ_EMIT, vals);
            if ($urandom_range(0, 3) == 0) send_pass(REQ_EMIT, vals);
            if ($urandom_range(0, 6) == 0) begin
                foreach (vals[i]) if (vals[i] == 32'h0) vals[i] = $urandom | 32'h1;
                send_pass(REQ_EMIT, vals);
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    w.req_type   = 1'($urandom_range(0, 1));
                    w.elem_value = random_element();
                    w.elem_last  = ($urandom_range(0, 3) == 0);
                    send_word(w);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 33;
        recv_idle_pct = 71;
        test_default_shape();
        test_float_sign();
        test_extreme_shape();
        test_output_backpressure();
        test_random_tensors(20);

        send_idle_pct = 71;
        recv_idle_pct = 33;
        test_random_tensors(20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_tensors(20);

        // Drain what is still owed, with a bound
        s_valid <= 1'b0;
        for (int i = 0; i < 20000 && owed_words.size() != 0; i++) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
        if (owed_words.size() != 0) begin
            faults += owed_words.size();
            $display("%0d owed words never arrived", owed_words.size());
        end

        $display("covered %0d elements over %0d shapes, float and integer data",
                 elements_sent, shapes_loaded);
        $display("checked %0d count reports and %0d coordinate words, %0d faults",
                 count_reports, coord_words, faults);
        if (faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("timeout: %0d words still owed", owed_words.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
